// File: design/ow_pkg.sv
// ow_pkg: shared types, codes and constants of the 1-wire bus master core
// depends on nothing; imported by ow_front, ow_back and the top level
package ow_pkg;

   // command codes on the op field
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
   localparam logic [2:0] CFG_RESET_RELEASE = 3'd1;
   localparam logic [2:0] CFG_PRES_LOW      = 3'd2;
   localparam logic [2:0] CFG_PRES_HIGH     = 3'd3;
   localparam logic [2:0] CFG_SHORT_SLOT    = 3'd4;
   localparam logic [2:0] CFG_LONG_SLOT     = 3'd5;
   localparam logic [2:0] CFG_READ_SAMPLE   = 3'd6;
   localparam logic [2:0] CFG_READ_RECOVERY = 3'd7;

   // configuration reset values
   localparam logic [9:0] RST_RESET_LOW     = 10'd750;
   localparam logic [7:0] RST_RESET_RELEASE = 8'd15;
   localparam logic [9:0] RST_PRES_LOW      = 10'd200;
   localparam logic [9:0] RST_PRES_HIGH     = 10'd240;
   localparam logic [7:0] RST_SHORT_SLOT    = 8'd2;
   localparam logic [7:0] RST_LONG_SLOT     = 8'd60;
   localparam logic [7:0] RST_READ_SAMPLE   = 8'd12;
   localparam logic [7:0] RST_READ_RECOVERY = 8'd50;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // tick queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'd0,
      PH_RST_LOW   = 4'd1,
      PH_RST_REL   = 4'd2,
      PH_PRES_LOW  = 4'd3,
      PH_PRES_HIGH = 4'd4,
      PH_WR_LOW    = 4'd5,
      PH_WR_HIGH   = 4'd6,
      PH_RD_LOW    = 4'd7,
      PH_RD_WAIT   = 4'd8,
      PH_RD_REC    = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_PRESENCE = 2'd1,
      ST_REJECTED    = 2'd2
   } status_type;

   // one classified tick as it sits in the queue
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] write_value;
      logic       line_level;
   } tick_type;

endpackage

// File: design/ow_front.sv
// ow_front: accepts tick transactions, decodes the command and queues them
// depends on ow_pkg; feeds ow_back
module ow_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [7:0]       req_write_value,
   input  logic             req_line_level,
   output logic             head_valid,
   output ow_pkg::tick_type head,
   input  logic             head_pop
);
   import ow_pkg::*;

   tick_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              push;
   tick_type          entry;

   // classify the command; the byte only travels with a write
   always_comb begin
      entry.line_level  = req_line_level;
      entry.write_value = 8'd0;
      unique case (req_op)
         OP_NONE:  entry.cmd = CMD_NONE;
         OP_RESET: entry.cmd = CMD_RESET;
         OP_WRITE: begin
            entry.cmd         = CMD_WRITE;
            entry.write_value = req_write_value;
         end
         OP_READ:  entry.cmd = CMD_READ;
         default:  entry.cmd = CMD_NONE;
      endcase
   end

   assign req_ready  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= entry;
      end
   end

   // queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (head_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !head_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && head_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: design/ow_back.sv
// ow_back: bus timing engine, configuration registers and result register
// depends on ow_pkg; takes queued ticks from ow_front
module ow_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [9:0]       csr_wdata,
   input  logic             head_valid,
   input  ow_pkg::tick_type head,
   output logic             head_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_pull_low,
   output logic             rsp_busy_res,
   output logic             rsp_finished,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_read_value
);
   import ow_pkg::*;

   typedef struct packed {
      logic [9:0] rst_low;
      logic [7:0] rst_rel;
      logic [9:0] pres_low;
      logic [9:0] pres_high;
      logic [7:0] short_slot;
      logic [7:0] long_slot;
      logic [7:0] sample;
      logic [7:0] recovery;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      logic [9:0] tcnt;
      logic [3:0] bits;
      logic [7:0] shift;
      logic [7:0] last;
      logic       done;
      logic       fin;
      status_type st;
      logic       pull;
   } eng_type;

   // configuration registers
   logic [9:0] cfg_rst_low_ff;
   logic [7:0] cfg_rst_rel_ff;
   logic [9:0] cfg_pres_low_ff;
   logic [9:0] cfg_pres_high_ff;
   logic [7:0] cfg_short_ff;
   logic [7:0] cfg_long_ff;
   logic [7:0] cfg_sample_ff;
   logic [7:0] cfg_recov_ff;
   cfg_type    cfg;

   // engine state
   phase_type  phase_ff;
   logic [9:0] tcnt_ff;
   logic [3:0] bits_ff;
   logic [7:0] shift_ff;
   logic [7:0] last_ff;
   logic       cont_ff;
   logic       pend_fin_ff;
   status_type pend_st_ff;
   logic       pend_rej_ff;

   // result register
   logic       rsp_valid_ff;
   logic       rsp_pull_ff;
   logic       rsp_busy_ff;
   logic       rsp_fin_ff;
   logic [1:0] rsp_status_ff;
   logic [7:0] rsp_read_ff;
   logic       rsp_pull_in;
   logic       rsp_busy_in;
   logic       rsp_fin_in;
   logic [1:0] rsp_status_in;
   logic [7:0] rsp_read_in;

   eng_type s0, s1, s2, s3, s4;
   logic    rej_now;
   logic    go;

   // one pass of the phase sequencer on a tick
   function automatic eng_type ow_step(eng_type e, logic line, cfg_type c);
      eng_type    r;
      logic [9:0] dur;
      logic [9:0] tnext;
      logic [3:0] bnext;
      logic       lvl;
      logic       one;
      r     = e;
      dur   = '0;
      lvl   = 1'b0;
      one   = e.shift[0];
      tnext = e.tcnt + 10'd1;
      bnext = e.bits + 4'd1;
      if (!e.done) begin
         unique case (e.phase)
            PH_RST_LOW: begin
               dur = c.rst_low;
               lvl = 1'b1;
            end
            PH_RST_REL: dur = {2'b00, c.rst_rel};
            PH_WR_LOW: begin
               dur = one ? {2'b00, c.short_slot} : {2'b00, c.long_slot};
               lvl = 1'b1;
            end
            PH_WR_HIGH: dur = one ? {2'b00, c.long_slot} : {2'b00, c.short_slot};
            PH_RD_LOW: begin
               dur = {2'b00, c.short_slot};
               lvl = 1'b1;
            end
            PH_RD_WAIT: dur = {2'b00, c.sample};
            PH_RD_REC:  dur = {2'b00, c.recovery};
            default:    dur = '0;
         endcase

         if (e.phase == PH_IDLE) begin
            r.done = 1'b1;
         end else if (e.phase == PH_PRES_LOW) begin
            // waiting for the device to pull the line low
            if (!line) begin
               r.phase = PH_PRES_HIGH;
               r.tcnt  = '0;
            end else begin
               r.tcnt = tnext;
               r.done = 1'b1;
               if (tnext >= c.pres_low) begin
                  r.phase = PH_IDLE;
                  r.tcnt  = '0;
                  r.fin   = 1'b1;
                  r.st    = ST_NO_PRESENCE;
               end
            end
         end else if (e.phase == PH_PRES_HIGH) begin
            // waiting for the device to release the line
            r.done = 1'b1;
            if (line) begin
               r.phase = PH_IDLE;
               r.tcnt  = '0;
               r.fin   = 1'b1;
               r.st    = ST_OK;
            end else begin
               r.tcnt = tnext;
               if (tnext >= c.pres_high) begin
                  r.phase = PH_IDLE;
                  r.tcnt  = '0;
                  r.fin   = 1'b1;
                  r.st    = ST_NO_PRESENCE;
               end
            end
         end else if (e.tcnt < dur) begin
            // timed part still running
            r.pull = lvl;
            r.tcnt = tnext;
            r.done = 1'b1;
         end else begin
            // timed part over: move on
            r.tcnt = '0;
            unique case (e.phase)
               PH_RST_LOW: r.phase = PH_RST_REL;
               PH_RST_REL: r.phase = PH_PRES_LOW;
               PH_WR_LOW:  r.phase = PH_WR_HIGH;
               PH_WR_HIGH: begin
                  r.shift = {1'b0, e.shift[7:1]};
                  r.bits  = bnext;
                  if (bnext >= BITS_PER_BYTE) begin
                     r.phase = PH_IDLE;
                     r.fin   = 1'b1;
                     r.st    = ST_OK;
                  end else begin
                     r.phase = PH_WR_LOW;
                  end
               end
               PH_RD_LOW: r.phase = PH_RD_WAIT;
               PH_RD_WAIT: begin
                  r.shift = {line, e.shift[7:1]};
                  r.phase = PH_RD_REC;
               end
               PH_RD_REC: begin
                  r.bits = bnext;
                  if (bnext >= BITS_PER_BYTE) begin
                     r.last  = e.shift;
                     r.phase = PH_IDLE;
                     r.fin   = 1'b1;
                     r.st    = ST_OK;
                  end else begin
                     r.phase = PH_RD_LOW;
                  end
               end
               default: r.phase = PH_IDLE;
            endcase
         end
      end
      return r;
   endfunction

   assign cfg = '{
      rst_low:    cfg_rst_low_ff,
      rst_rel:    cfg_rst_rel_ff,
      pres_low:   cfg_pres_low_ff,
      pres_high:  cfg_pres_high_ff,
      short_slot: cfg_short_ff,
      long_slot:  cfg_long_ff,
      sample:     cfg_sample_ff,
      recovery:   cfg_recov_ff
   };

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_rst_low_ff   <= RST_RESET_LOW;
         cfg_rst_rel_ff   <= RST_RESET_RELEASE;
         cfg_pres_low_ff  <= RST_PRES_LOW;
         cfg_pres_high_ff <= RST_PRES_HIGH;
         cfg_short_ff     <= RST_SHORT_SLOT;
         cfg_long_ff      <= RST_LONG_SLOT;
         cfg_sample_ff    <= RST_READ_SAMPLE;
         cfg_recov_ff     <= RST_READ_RECOVERY;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CFG_RESET_LOW:     cfg_rst_low_ff   <= csr_wdata;
            CFG_RESET_RELEASE: cfg_rst_rel_ff   <= csr_wdata[7:0];
            CFG_PRES_LOW:      cfg_pres_low_ff  <= csr_wdata;
            CFG_PRES_HIGH:     cfg_pres_high_ff <= csr_wdata;
            CFG_SHORT_SLOT:    cfg_short_ff     <= csr_wdata[7:0];
            CFG_LONG_SLOT:     cfg_long_ff      <= csr_wdata[7:0];
            CFG_READ_SAMPLE:   cfg_sample_ff    <= csr_wdata[7:0];
            CFG_READ_RECOVERY: cfg_recov_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // a tick runs when one is queued and the result register can take it
   assign go       = head_valid && (!rsp_valid_ff || rsp_ready);
   assign head_pop = go && s4.done;

   // next state: command start, then four sequencer passes
   always_comb begin
      s0.phase = phase_ff;
      s0.tcnt  = tcnt_ff;
      s0.bits  = bits_ff;
      s0.shift = shift_ff;
      s0.last  = last_ff;
      s0.done  = 1'b0;
      s0.pull  = 1'b0;
      if (cont_ff) begin
         s0.fin  = pend_fin_ff;
         s0.st   = pend_st_ff;
         rej_now = pend_rej_ff;
      end else begin
         s0.fin  = 1'b0;
         s0.st   = ST_OK;
         rej_now = (head.cmd != CMD_NONE) && (phase_ff != PH_IDLE);
         if ((head.cmd != CMD_NONE) && (phase_ff == PH_IDLE)) begin
            s0.bits = '0;
            s0.tcnt = '0;
            unique case (head.cmd)
               CMD_RESET: s0.phase = PH_RST_LOW;
               CMD_WRITE: begin
                  s0.shift = head.write_value;
                  s0.phase = PH_WR_LOW;
               end
               CMD_READ: begin
                  s0.shift = 8'd0;
                  s0.phase = PH_RD_LOW;
               end
               default: s0.phase = phase_ff;
            endcase
         end
      end
      s1 = ow_step(s0, head.line_level, cfg);
      s2 = ow_step(s1, head.line_level, cfg);
      s3 = ow_step(s2, head.line_level, cfg);
      s4 = ow_step(s3, head.line_level, cfg);
   end

   // outputs of the finished tick
   always_comb begin
      rsp_pull_in = s4.pull;
      rsp_busy_in = (s4.phase != PH_IDLE);
      rsp_fin_in  = s4.fin || rej_now;
      rsp_read_in = s4.last;
      if (s4.fin) begin
         rsp_status_in = s4.st;
      end else if (rej_now) begin
         rsp_status_in = ST_REJECTED;
      end else begin
         rsp_status_in = ST_OK;
      end
   end

   // engine registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         tcnt_ff     <= '0;
         bits_ff     <= '0;
         shift_ff    <= '0;
         last_ff     <= '0;
         cont_ff     <= 1'b0;
         pend_fin_ff <= 1'b0;
         pend_st_ff  <= ST_OK;
         pend_rej_ff <= 1'b0;
      end else if (go) begin
         phase_ff    <= s4.phase;
         tcnt_ff     <= s4.tcnt;
         bits_ff     <= s4.bits;
         shift_ff    <= s4.shift;
         last_ff     <= s4.last;
         cont_ff     <= !s4.done;
         pend_fin_ff <= s4.fin;
         pend_st_ff  <= s4.st;
         pend_rej_ff <= rej_now;
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (head_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (head_pop) begin
         rsp_pull_ff   <= rsp_pull_in;
         rsp_busy_ff   <= rsp_busy_in;
         rsp_fin_ff    <= rsp_fin_in;
         rsp_status_ff <= rsp_status_in;
         rsp_read_ff   <= rsp_read_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pull_low   = rsp_pull_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_finished   = rsp_fin_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_ff;

endmodule

// File: design/one_wire_bus_master_core.sv
// one_wire_bus_master_core: one result transaction per tick transaction.
// an accepted tick is written to the tick queue and its result to the result register.
// throughput: one tick per cycle while the result register can take it; the
//   sequencer evaluates up to four phases per cycle, and a tick whose chain
//   of zero-length parts runs longer stays queued and resumes from saved state.
// reset: synchronous, active high; clears queue, engine and result valid and
//   loads the default timing registers.
module one_wire_bus_master_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [7:0] req_write_value,
   input  logic       req_line_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_pull_low,
   output logic       rsp_busy_res,
   output logic       rsp_finished,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_read_value
);
   import ow_pkg::*;

   tick_type head;
   logic     head_valid;
   logic     head_pop;

   // accept and classify ticks
   ow_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_write_value (req_write_value),
      .req_line_level  (req_line_level),
      .head_valid      (head_valid),
      .head            (head),
      .head_pop        (head_pop)
   );

   // run the bus timing and deliver results
   ow_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .head_valid     (head_valid),
      .head           (head),
      .head_pop       (head_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pull_low   (rsp_pull_low),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_finished   (rsp_finished),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

endmodule

// File: design/ow_checker.sv
// ow_checker: port-level assertions for one_wire_bus_master_core
// depends on nothing but the top level's ports; attached by the bind below
module ow_checker (
   input logic       clock,
   input logic       reset,
   input logic       csr_wr_en,
   input logic [2:0] csr_index,
   input logic [9:0] csr_wdata,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_op,
   input logic [7:0] req_write_value,
   input logic       req_line_level,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_pull_low,
   input logic       rsp_busy_res,
   input logic       rsp_finished,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_read_value
);

   // a nonzero status only comes with the finished pulse
   a_status_needs_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_finished || (rsp_status == 2'd0)))
      else $error("status set without finished");

   // status code three is never produced
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("status out of range");

   // the line is only driven while a command is running
   a_pull_implies_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pull_low) |-> rsp_busy_res)
      else $error("pull low while not busy");

   // a rejected command leaves the running one in progress
   a_reject_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == 2'd2)) |-> rsp_busy_res)
      else $error("rejection reported while idle");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_finished)))
      else $error("stalled result changed");

endmodule

bind one_wire_bus_master_core ow_checker u_ow_checker (.*);

// File: tb/tb_top.sv
// tb_top: self-checking bench for the 1-wire bus master core
// keeps its own tick-accurate copy of the bus sequencer to predict every result
// depends on ow_pkg and one_wire_bus_master_core
`timescale 1ns / 100ps

module tb_top;
   import ow_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int END_CYCLES = 20;

   // one expected result transaction
   typedef struct packed {
      logic       pull_low;
      logic       busy;
      logic       finished;
      logic [1:0] status;
      logic [7:0] read_value;
   } bus_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [2:0] csr_index = CFG_RESET_LOW;
   logic [9:0] csr_wdata = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_op = OP_NONE;
   logic [7:0] req_write_value = '0;
   logic       req_line_level = 1'b1;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_pull_low;
   logic       rsp_busy_res;
   logic       rsp_finished;
   logic [1:0] rsp_status;
   logic [7:0] rsp_read_value;

   // predicted bus sequencer state and timing registers
   logic [9:0]  cfg_reg [8];
   phase_type   ph;
   int unsigned tcnt;
   logic [3:0]  bcnt;
   logic [7:0]  shreg;
   logic [7:0]  last_rd;

   bus_out_type pending_outputs[$];
   int       mismatch_count = 0;
   int       cycle_count = 0;
   int       ticks_sent = 0;
   int       idle_pct = 0;
   int       stall_pct = 0;
   int       noise_pct = 0;
   int       hold_request = 0;
   int       hold_served = 0;
   int       hold_cnt = 0;
   int       pres_hi_left = 0;
   int       pres_lo_left = 0;

   one_wire_bus_master_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_write_value (req_write_value),
      .req_line_level  (req_line_level),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pull_low    (rsp_pull_low),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_finished    (rsp_finished),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (hold_request != hold_served) begin
         hold_served <= hold_request;
         hold_cnt <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic void check_field(input string name, input int unsigned exp_v,
                                       input int unsigned act_v);
      if (exp_v != act_v) begin
         mismatch_count++;
         $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      end
   endfunction

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      bus_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result, expected none actual %0h", $time,
                     {rsp_pull_low, rsp_busy_res, rsp_finished, rsp_status, rsp_read_value});
         end else begin
            want = pending_outputs.pop_front();
            check_field("pull_low", want.pull_low, rsp_pull_low);
            check_field("busy", want.busy, rsp_busy_res);
            check_field("finished", want.finished, rsp_finished);
            check_field("status", want.status, rsp_status);
            check_field("read_value", want.read_value, rsp_read_value);
         end
      end
   end

   function automatic void go_phase(input phase_type p);
      ph = p;
      tcnt = 0;
   endfunction

   // one bus tick of the sequencer: zero-length parts fall through in the same tick
   function automatic bus_out_type advance_bus_tick(input logic [1:0] op, input logic [7:0] wv,
                                                    input logic line);
      bus_out_type o;
      logic        rejected;
      logic        fin;
      logic        run;
      logic        one;
      logic        lvl;
      logic [1:0]  st;
      int unsigned dur;
      o = '0;
      rejected = 1'b0;
      fin = 1'b0;
      run = 1'b1;
      st = ST_OK;
      // start a command or refuse it while busy
      if (op != OP_NONE) begin
         if (ph != PH_IDLE) begin
            rejected = 1'b1;
         end else begin
            bcnt = '0;
            if (op == OP_RESET) begin
               go_phase(PH_RST_LOW);
            end else if (op == OP_WRITE) begin
               shreg = wv;
               go_phase(PH_WR_LOW);
            end else begin
               shreg = '0;
               go_phase(PH_RD_LOW);
            end
         end
      end
      while (run) begin
         one = shreg[0];
         dur = 0;
         lvl = 1'b0;
         case (ph)
            PH_RST_LOW: begin
               dur = cfg_reg[CFG_RESET_LOW];
               lvl = 1'b1;
            end
            PH_RST_REL: dur = cfg_reg[CFG_RESET_RELEASE];
            PH_WR_LOW: begin
               dur = one ? cfg_reg[CFG_SHORT_SLOT] : cfg_reg[CFG_LONG_SLOT];
               lvl = 1'b1;
            end
            PH_WR_HIGH: dur = one ? cfg_reg[CFG_LONG_SLOT] : cfg_reg[CFG_SHORT_SLOT];
            PH_RD_LOW: begin
               dur = cfg_reg[CFG_SHORT_SLOT];
               lvl = 1'b1;
            end
            PH_RD_WAIT: dur = cfg_reg[CFG_READ_SAMPLE];
            PH_RD_REC: dur = cfg_reg[CFG_READ_RECOVERY];
            default: ;
         endcase
         if (ph == PH_IDLE) begin
            run = 1'b0;
         end else if (ph == PH_PRES_LOW) begin
            // waiting for the device to pull low
            if (!line) begin
               go_phase(PH_PRES_HIGH);
            end else begin
               tcnt++;
               if (tcnt >= cfg_reg[CFG_PRES_LOW]) begin
                  go_phase(PH_IDLE);
                  fin = 1'b1;
                  st = ST_NO_PRESENCE;
               end
               run = 1'b0;
            end
         end else if (ph == PH_PRES_HIGH) begin
            // waiting for the device to let go
            if (line) begin
               go_phase(PH_IDLE);
               fin = 1'b1;
               st = ST_OK;
            end else begin
               tcnt++;
               if (tcnt >= cfg_reg[CFG_PRES_HIGH]) begin
                  go_phase(PH_IDLE);
                  fin = 1'b1;
                  st = ST_NO_PRESENCE;
               end
            end
            run = 1'b0;
         end else if (tcnt < dur) begin
            o.pull_low = lvl;
            tcnt++;
            run = 1'b0;
         end else begin
            case (ph)
               PH_RST_LOW: go_phase(PH_RST_REL);
               PH_RST_REL: go_phase(PH_PRES_LOW);
               PH_WR_LOW: go_phase(PH_WR_HIGH);
               PH_WR_HIGH: begin
                  shreg = shreg >> 1;
                  bcnt++;
                  if (bcnt >= BITS_PER_BYTE) begin
                     go_phase(PH_IDLE);
                     fin = 1'b1;
                  end else begin
                     go_phase(PH_WR_LOW);
                  end
               end
               PH_RD_LOW: go_phase(PH_RD_WAIT);
               PH_RD_WAIT: begin
                  shreg = {line, shreg[7:1]};
                  go_phase(PH_RD_REC);
               end
               PH_RD_REC: begin
                  bcnt++;
                  if (bcnt >= BITS_PER_BYTE) begin
                     last_rd = shreg;
                     go_phase(PH_IDLE);
                     fin = 1'b1;
                  end else begin
                     go_phase(PH_RD_LOW);
                  end
               end
               default: go_phase(PH_IDLE);
            endcase
         end
      end
      if (!fin && rejected) begin
         fin = 1'b1;
         st = ST_REJECTED;
      end
      o.busy = (ph != PH_IDLE);
      o.finished = fin;
      o.status = fin ? st : ST_OK;
      o.read_value = last_rd;
      return o;
   endfunction

   // look ahead: would a plain tick with this line level complete the command
   function automatic logic next_tick_finishes(input logic line);
      phase_type   s_ph;
      int unsigned s_tcnt;
      logic [3:0]  s_bcnt;
      logic [7:0]  s_sh;
      logic [7:0]  s_rd;
      bus_out_type o;
      s_ph = ph;
      s_tcnt = tcnt;
      s_bcnt = bcnt;
      s_sh = shreg;
      s_rd = last_rd;
      o = advance_bus_tick(OP_NONE, 8'h00, line);
      ph = s_ph;
      tcnt = s_tcnt;
      bcnt = s_bcnt;
      shreg = s_sh;
      last_rd = s_rd;
      return o.finished;
   endfunction

   // device on the wire: high for a while, then a presence pulse of a given length
   function automatic logic device_line();
      case (ph)
         PH_RST_LOW, PH_RST_REL, PH_PRES_LOW: begin
            if (pres_hi_left > 0) begin
               if (ph == PH_PRES_LOW) pres_hi_left--;
               return 1'b1;
            end
            return 1'b0;
         end
         PH_PRES_HIGH: begin
            if (pres_lo_left > 0) begin
               pres_lo_left--;
               return 1'b0;
            end
            return 1'b1;
         end
         default: return 1'($urandom);
      endcase
   endfunction

   // offer one tick transaction and record its prediction when taken
   task automatic send_tick(input logic [1:0] op, input logic [7:0] wv, input logic line);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_write_value <= wv;
      req_line_level <= line;
      do @(posedge clock); while (!req_ready);
      pending_outputs.push_back(advance_bus_tick(op, wv, line));
      ticks_sent++;
   endtask

   // sender pauses until every prediction has been matched
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_timing(input logic [9:0] r0, input logic [9:0] r1, input logic [9:0] r2,
                             input logic [9:0] r3, input logic [9:0] r4, input logic [9:0] r5,
                             input logic [9:0] r6, input logic [9:0] r7);
      logic [9:0] vals [8];
      vals[0] = r0;
      vals[1] = r1;
      vals[2] = r2;
      vals[3] = r3;
      vals[4] = r4;
      vals[5] = r5;
      vals[6] = r6;
      vals[7] = r7;
      wait_drained();
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         // 8-bit registers drop the upper bits
         if (i == CFG_RESET_LOW || i == CFG_PRES_LOW || i == CFG_PRES_HIGH) begin
            cfg_reg[i] = vals[i];
         end else begin
            cfg_reg[i] = {2'b00, vals[i][7:0]};
         end
      end
      csr_wr_en <= 1'b0;
   endtask

   // small random timing, junk in the unused upper bits of 8-bit registers
   task automatic random_timing();
      set_timing(10'($urandom_range(0, 6)),
                 {2'($urandom), 8'($urandom_range(0, 3))},
                 10'($urandom_range(0, 6)),
                 10'($urandom_range(0, 6)),
                 {2'($urandom), 8'($urandom_range(0, 3))},
                 {2'($urandom), 8'($urandom_range(0, 5))},
                 {2'($urandom), 8'($urandom_range(0, 3))},
                 {2'($urandom), 8'($urandom_range(0, 3))});
   endtask

   // one command and the ticks it takes, with stray commands mixed in
   task automatic run_command(input logic [1:0] op, input logic [7:0] wv,
                              input int hi, input int lo);
      logic [1:0] next_op;
      logic       line;
      pres_hi_left = hi;
      pres_lo_left = lo;
      send_tick(op, wv, 1'($urandom));
      while (ph != PH_IDLE) begin
         line = device_line();
         next_op = OP_NONE;
         if ($urandom_range(99) < noise_pct ||
             (next_tick_finishes(line) && $urandom_range(99) < 4 * noise_pct)) begin
            next_op = 2'($urandom_range(1, 3));
         end
         send_tick(next_op, 8'($urandom), line);
      end
   endtask

   task automatic run_commands_for(input int n);
      int stop_at;
      stop_at = ticks_sent + n;
      while (ticks_sent < stop_at) begin
         repeat ($urandom_range(2)) send_tick(OP_NONE, 8'($urandom), 1'($urandom));
         run_command(2'($urandom_range(1, 3)), 8'($urandom),
                     $urandom_range(0, cfg_reg[CFG_PRES_LOW] + 1),
                     $urandom_range(0, cfg_reg[CFG_PRES_HIGH] + 1));
      end
   endtask

   // default slot timing straight out of reset
   task automatic test_reset_defaults();
      noise_pct = 0;
      run_command(OP_WRITE, 8'hA5, 0, 0);
   endtask

   // field extremes, every command, rejection and a command on the finishing tick
   task automatic test_directed();
      logic [1:0] next_op;
      int         k;
      set_timing(10'd1, 10'd0, 10'd2, 10'd2, 10'd0, 10'd1, 10'd0, 10'd0);
      noise_pct = 0;
      send_tick(OP_NONE, 8'h00, 1'b0);
      send_tick(OP_NONE, 8'hFF, 1'b1);
      // zero-length read slots take the whole byte in one tick
      send_tick(OP_READ, 8'h00, 1'b1);
      send_tick(OP_READ, 8'hFF, 1'b0);
      send_tick(OP_WRITE, 8'hFF, 1'b1);
      k = 0;
      while (ph != PH_IDLE) begin
         k++;
         if (next_tick_finishes(1'b1)) begin
            next_op = OP_RESET;
         end else if (k == 2) begin
            next_op = OP_READ;
         end else begin
            next_op = OP_NONE;
         end
         send_tick(next_op, 8'h00, 1'b1);
      end
      // presence ok, no pull low, line stuck low
      run_command(OP_RESET, 8'h00, 0, 0);
      run_command(OP_RESET, 8'h00, 5, 0);
      run_command(OP_RESET, 8'h00, 0, 5);
   endtask

   task automatic test_random_traffic(input int idle, input int stall);
      random_timing();
      idle_pct = idle;
      stall_pct = stall;
      noise_pct = 5;
      run_commands_for(20);
   endtask

   // long receiver hold-off fills the core, then a full pause of the sender
   task automatic test_backpressure();
      idle_pct = 0;
      stall_pct = 0;
      random_timing();
      hold_request <= hold_request + 1;
      run_commands_for(15);
      wait_drained();
      run_commands_for(15);
   endtask

   // all parts zero length, presence limits of zero
   task automatic test_zero_timing();
      set_timing('0, '0, '0, '0, '0, '0, '0, '0);
      run_commands_for(25);
   endtask

   // widest presence limits, junk above the 8-bit registers
   task automatic test_max_timing();
      set_timing(10'd3, 10'h300, 10'h3FF, 10'h3FF, 10'h301, 10'h302, 10'h3FF, 10'h3FF);
      idle_pct = 0;
      stall_pct = 0;
      noise_pct = 1;
      // late presence pulse well inside the limits
      run_command(OP_RESET, 8'h00, 20, 30);
      run_command(OP_WRITE, 8'h96, 0, 0);
   endtask

   initial begin
      cfg_reg[CFG_RESET_LOW] = RST_RESET_LOW;
      cfg_reg[CFG_RESET_RELEASE] = {2'b00, RST_RESET_RELEASE};
      cfg_reg[CFG_PRES_LOW] = RST_PRES_LOW;
      cfg_reg[CFG_PRES_HIGH] = RST_PRES_HIGH;
      cfg_reg[CFG_SHORT_SLOT] = {2'b00, RST_SHORT_SLOT};
      cfg_reg[CFG_LONG_SLOT] = {2'b00, RST_LONG_SLOT};
      cfg_reg[CFG_READ_SAMPLE] = {2'b00, RST_READ_SAMPLE};
      cfg_reg[CFG_READ_RECOVERY] = {2'b00, RST_READ_RECOVERY};
      ph = PH_IDLE;
      tcnt = 0;
      bcnt = '0;
      shreg = '0;
      last_rd = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed();
      test_random_traffic(0, 0);
      test_random_traffic(69, 0);
      test_random_traffic(0, 69);
      test_random_traffic(24, 24);
      test_backpressure();
      test_zero_timing();
      test_max_timing();

      // drain and let the core settle
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
